// ===== design/affine_orbit_canonical_gf256_macros.svh =====
// Assertion macros shared by the design files
`ifndef AFFINE_ORBIT_CANONICAL_GF256_MACROS_SVH
`define AFFINE_ORBIT_CANONICAL_GF256_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define AOC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("aoc assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define AOC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("aoc assertion failed");

`endif

// ===== design/aoc_pkg.sv =====
package aoc_pkg;

	localparam int MAX_WEIGHT_DEF = 22;
	localparam int FIELD_POLY = 'h14d;
	localparam int GROUP_ORDER = 65280;
	localparam int ZERO_POS = 255;
	localparam int LIMB_W = 64;
	localparam int WORD_W = 256;
	localparam int STAB_W = 9;
	localparam int TOTAL_W = 9;

	typedef logic [7:0] tab_t [256];

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_HIGH  = 2'd1,
		ST_LOW   = 2'd2,
		ST_NODIV = 2'd3
	} status_t;

	// One pair request from the sequencer to the image unit
	typedef struct packed {
		logic       valid;
		logic [7:0] xi;
		logic [7:0] xj;
	} pair_req_t;

	function automatic tab_t build_exp();
		tab_t t;
		int   e;
		e = 1;
		for (int i = 0; i < 255; i++) begin
			t[i] = e[7:0];
			e = e << 1;
			if ((e & 256) != 0) e = e ^ FIELD_POLY;
		end
		t[255] = 8'd0;
		return t;
	endfunction

	function automatic tab_t build_log();
		tab_t t;
		int   e;
		e = 1;
		t[0] = 8'(ZERO_POS);
		for (int i = 0; i < 255; i++) begin
			t[e] = 8'(i);
			e = e << 1;
			if ((e & 256) != 0) e = e ^ FIELD_POLY;
		end
		return t;
	endfunction

	localparam tab_t EXP_TAB = build_exp();
	localparam tab_t LOG_TAB = build_log();

	// True when c is one of the divisors 2^a * 3^b * 5^c * 17^d of the group order
	function automatic logic divides_order(input logic [15:0] c);
		logic hit;
		int   v;
		hit = 1'b0;
		for (int a = 0; a < 9; a++) begin
			for (int m = 0; m < 8; m++) begin
				v = (1 << a) * (((m & 1) != 0) ? 3 : 1) * (((m & 2) != 0) ? 5 : 1)
					* (((m & 4) != 0) ? 17 : 1);
				if (c == 16'(v)) hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

// ===== design/affine_orbit_canonical_gf256.sv =====
// Affine orbit canonical form over GF(256). Raise start with the four limbs while busy is low;
// the word is taken at that edge and busy stays high until the result is ready. The result
// appears for one cycle with done high and must be captured then: there is no way to hold it.
// One word runs through a support scan (one bit a cycle), a weight check, a pair sweep over
// every ordered index pair of the lanes through the shared image unit, a pipeline drain, a
// result load and the result cycle. A word whose weight does not match is rejected after
// the scan and the check, without a pair sweep.
module affine_orbit_canonical_gf256 #(
	parameter int MAX_WEIGHT = aoc_pkg::MAX_WEIGHT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [4:0]                  cfg_wdata,
	input  logic                        start,
	output logic                        busy,
	input  logic [aoc_pkg::LIMB_W-1:0]  limb0,
	input  logic [aoc_pkg::LIMB_W-1:0]  limb1,
	input  logic [aoc_pkg::LIMB_W-1:0]  limb2,
	input  logic [aoc_pkg::LIMB_W-1:0]  limb3,
	output logic                        done,
	output logic [aoc_pkg::LIMB_W-1:0]  best0,
	output logic [aoc_pkg::LIMB_W-1:0]  best1,
	output logic [aoc_pkg::LIMB_W-1:0]  best2,
	output logic [aoc_pkg::LIMB_W-1:0]  best3,
	output logic [aoc_pkg::STAB_W-1:0]  stabilizer,
	output logic [1:0]                  status
);

	`include "affine_orbit_canonical_gf256_macros.svh"

	localparam int IDXW = (MAX_WEIGHT > 1) ? $clog2(MAX_WEIGHT) : 1;
	localparam int CNTW = $clog2(MAX_WEIGHT * (MAX_WEIGHT - 1) + 1);
	localparam logic [IDXW-1:0] LAST_IDX = IDXW'(MAX_WEIGHT - 1);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SCAN  = 6'b000010,
		S_CHECK = 6'b000100,
		S_PAIR  = 6'b001000,
		S_DRAIN = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	state_t                       state_q;
	logic [4:0]                   weight_q;
	logic [aoc_pkg::WORD_W-1:0]   word_q;
	logic [7:0]                   scan_q;
	logic [aoc_pkg::TOTAL_W-1:0]  total_q;
	logic [7:0]                   sup_q  [MAX_WEIGHT];
	logic [MAX_WEIGHT-1:0]        sval_q;
	logic [7:0]                   ri_q   [MAX_WEIGHT];
	logic [MAX_WEIGHT-1:0]        riv_q;
	logic [7:0]                   rj_q   [MAX_WEIGHT];
	logic [MAX_WEIGHT-1:0]        rjv_q;
	logic [IDXW-1:0]              ic_q;
	logic [IDXW-1:0]              jc_q;
	logic                         err_q;
	aoc_pkg::status_t             errc_q;
	logic [aoc_pkg::WORD_W-1:0]   best_q;
	logic [CNTW-1:0]              count_q;
	logic                         done_q;
	logic                         drain_q;
	logic [aoc_pkg::WORD_W-1:0]   out_word_q;
	logic [aoc_pkg::STAB_W-1:0]   out_stab_q;
	aoc_pkg::status_t             out_status_q;

	aoc_pkg::pair_req_t           pair;
	logic                         img_valid;
	logic [aoc_pkg::WORD_W-1:0]   img;
	logic [7:0]                   elem;
	logic                         fill;

	assign elem = (scan_q == 8'(aoc_pkg::ZERO_POS)) ? 8'd0 : aoc_pkg::EXP_TAB[scan_q];
	assign fill = (state_q == S_SCAN) && word_q[0] &&
		(total_q < aoc_pkg::TOTAL_W'(MAX_WEIGHT));

	// Issue one ordered pair per sweep cycle, except where ic equals jc or either lane is empty
	assign pair.valid = (state_q == S_PAIR) && riv_q[0] && rjv_q[0] && (ic_q != jc_q);
	assign pair.xi    = ri_q[0];
	assign pair.xj    = rj_q[0];

	aoc_image #(
		.MAX_WEIGHT(MAX_WEIGHT)
	) u_image (
		.clk      (clk),
		.arst_n   (arst_n),
		.pair     (pair),
		.sup      (sup_q),
		.sval     (sval_q),
		.img_valid(img_valid),
		.img      (img)
	);

	// Hold the weight register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= 5'd14;
		end else if (cfg_we) begin
			weight_q <= cfg_wdata;
		end
	end

	// Track the first drain cycle, when the last pair is still in the first stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q <= 1'b0;
		end else begin
			drain_q <= (state_q == S_PAIR);
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			scan_q  <= '0;
			total_q <= '0;
			sval_q  <= '0;
			riv_q   <= '0;
			rjv_q   <= '0;
			ic_q    <= '0;
			jc_q    <= '0;
			err_q   <= 1'b0;
			errc_q  <= aoc_pkg::ST_OK;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_FIN);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_SCAN;
						scan_q  <= '0;
						total_q <= '0;
						sval_q  <= '0;
						riv_q   <= '0;
						rjv_q   <= '0;
						count_q <= '0;
						err_q   <= 1'b0;
					end
				end
				S_SCAN: begin
					if (word_q[0]) total_q <= total_q + 1'b1;
					if (fill) begin
						sval_q <= {1'b1, sval_q[MAX_WEIGHT-1:1]};
						riv_q  <= {1'b1, riv_q[MAX_WEIGHT-1:1]};
						rjv_q  <= {1'b1, rjv_q[MAX_WEIGHT-1:1]};
					end
					scan_q <= scan_q + 1'b1;
					if (scan_q == 8'd255) state_q <= S_CHECK;
				end
				S_CHECK: begin
					ic_q <= '0;
					jc_q <= '0;
					if (total_q > aoc_pkg::TOTAL_W'(weight_q) ||
						total_q > aoc_pkg::TOTAL_W'(MAX_WEIGHT)) begin
						err_q   <= 1'b1;
						errc_q  <= aoc_pkg::ST_HIGH;
						state_q <= S_FIN;
					end else if (total_q < aoc_pkg::TOTAL_W'(weight_q)) begin
						err_q   <= 1'b1;
						errc_q  <= aoc_pkg::ST_LOW;
						state_q <= S_FIN;
					end else begin
						state_q <= S_PAIR;
					end
				end
				S_PAIR: begin
					rjv_q <= {rjv_q[0], rjv_q[MAX_WEIGHT-1:1]};
					if (jc_q == LAST_IDX) begin
						jc_q  <= '0;
						riv_q <= {riv_q[0], riv_q[MAX_WEIGHT-1:1]};
						if (ic_q == LAST_IDX) begin
							state_q <= S_DRAIN;
						end else begin
							ic_q <= ic_q + 1'b1;
						end
					end else begin
						jc_q <= jc_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (!drain_q && !img_valid) state_q <= S_FIN;
				end
				S_FIN: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase

			// Keep the least image and count its ties
			if (img_valid) begin
				if (img < best_q) begin
					count_q <= CNTW'(1);
				end else if (img == best_q) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	// Payload: word shift, support lanes, rotating copies, least image, result registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			word_q <= {limb3, limb2, limb1, limb0};
			best_q <= '1;
		end else if (state_q == S_SCAN) begin
			word_q <= {1'b0, word_q[aoc_pkg::WORD_W-1:1]};
		end
		if (fill) begin
			for (int k = 0; k < MAX_WEIGHT - 1; k++) begin
				sup_q[k] <= sup_q[k+1];
				ri_q[k]  <= ri_q[k+1];
				rj_q[k]  <= rj_q[k+1];
			end
			sup_q[MAX_WEIGHT-1] <= elem;
			ri_q[MAX_WEIGHT-1]  <= elem;
			rj_q[MAX_WEIGHT-1]  <= elem;
		end
		if (state_q == S_PAIR) begin
			for (int k = 0; k < MAX_WEIGHT; k++) begin
				rj_q[k] <= rj_q[(k + 1) % MAX_WEIGHT];
			end
			if (jc_q == LAST_IDX) begin
				for (int k = 0; k < MAX_WEIGHT; k++) begin
					ri_q[k] <= ri_q[(k + 1) % MAX_WEIGHT];
				end
			end
		end
		if (img_valid && img < best_q) best_q <= img;
		if (state_q == S_FIN) begin
			if (err_q) begin
				out_word_q   <= '1;
				out_stab_q   <= '0;
				out_status_q <= errc_q;
			end else begin
				out_word_q   <= best_q;
				out_stab_q   <= aoc_pkg::STAB_W'(count_q);
				out_status_q <= (count_q == '0 || !aoc_pkg::divides_order(16'(count_q))) ?
					aoc_pkg::ST_NODIV : aoc_pkg::ST_OK;
			end
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign best0      = out_word_q[63:0];
	assign best1      = out_word_q[127:64];
	assign best2      = out_word_q[191:128];
	assign best3      = out_word_q[255:192];
	assign stabilizer = out_stab_q;
	assign status     = out_status_q;

	`AOC_ASSERT_NOW(a_done_not_busy, done, !busy)
	`AOC_ASSERT_NEXT(a_start_sets_busy, start && !busy, busy)
	`AOC_ASSERT_NOW(a_err_no_stab, done && (status == aoc_pkg::ST_HIGH || status == aoc_pkg::ST_LOW), stabilizer == '0)
	`AOC_ASSERT_NOW(a_no_pair_outside_sweep, img_valid, state_q == S_PAIR || state_q == S_DRAIN)

endmodule

// ===== design/aoc_image.sv =====
module aoc_image #(
	parameter int MAX_WEIGHT = aoc_pkg::MAX_WEIGHT_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  aoc_pkg::pair_req_t        pair,
	input  logic [7:0]                sup [MAX_WEIGHT],
	input  logic [MAX_WEIGHT-1:0]     sval,
	output logic                      img_valid,
	output logic [aoc_pkg::WORD_W-1:0] img
);

	`include "affine_orbit_canonical_gf256_macros.svh"

	logic [7:0]            pos_c  [MAX_WEIGHT];
	logic [7:0]            pos_s1 [MAX_WEIGHT];
	logic [MAX_WEIGHT-1:0] lv_s1;
	logic                  v_s1;
	logic [aoc_pkg::WORD_W-1:0] img_c;
	logic [aoc_pkg::WORD_W-1:0] img_s2;
	logic                  v_s2;

	// Map every lane: position of (y + xi) / (xj + xi) as log difference mod 255
	always_comb begin
		logic [7:0] d;
		logic [7:0] ld;
		logic [7:0] a;
		logic [8:0] s;
		d  = pair.xi ^ pair.xj;
		ld = aoc_pkg::LOG_TAB[d];
		for (int k = 0; k < MAX_WEIGHT; k++) begin
			a = sup[k] ^ pair.xi;
			s = {1'b0, aoc_pkg::LOG_TAB[a]} + 9'd255 - {1'b0, ld};
			if (s >= 9'd255) s = s - 9'd255;
			pos_c[k] = (a == 8'd0) ? 8'(aoc_pkg::ZERO_POS) : s[7:0];
		end
	end

	// Hold lane positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= pair.valid;
		end
	end

	always_ff @(posedge clk) begin
		pos_s1 <= pos_c;
		lv_s1  <= sval;
	end

	// Build the image word from the lane positions
	always_comb begin
		img_c = '0;
		for (int k = 0; k < MAX_WEIGHT; k++) begin
			if (lv_s1[k]) img_c[pos_s1[k]] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		img_s2 <= img_c;
	end

	assign img_valid = v_s2;
	assign img       = img_s2;

	`AOC_ASSERT_NEXT(a_s1_follows_req, pair.valid, v_s1)
	`AOC_ASSERT_NEXT(a_s2_follows_s1, v_s1, v_s2)
	`AOC_ASSERT_NOW(a_img_has_source, v_s2, $past(v_s1))

endmodule
